@@ src/rq_pkg.sv @@
// shared types and constants for the rayleigh quotient core
`default_nettype none
package rq_pkg;

  localparam int ACC_W  = 48;
  localparam int TERM_W = 33;
  localparam int OUT_W  = 32;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};

  localparam int Q_DEPTH = 2;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [ACC_W-1:0] numer;
    logic signed [ACC_W-1:0] denom;
  } rq_sums_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } rq_state_t;

endpackage
`default_nettype wire

@@ src/rq_front.sv @@
// front end: product stage and saturating multiply-accumulate per element
`default_nettype none
module rq_front import rq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] vec_re,
  input  wire logic signed [15:0] vec_im,
  input  wire logic signed [15:0] prod_re,
  input  wire logic signed [15:0] prod_im,
  input  wire logic               last_elem,
  input  wire logic               q_full,
  output logic                    push,
  output rq_sums_t                push_data
);

  logic                    s1_valid;
  logic                    s1_last;
  logic signed [31:0]      p_rr;
  logic signed [31:0]      p_ii;
  logic signed [31:0]      p_vr;
  logic signed [31:0]      p_vi;
  logic signed [ACC_W-1:0] numer_acc;
  logic signed [ACC_W-1:0] denom_acc;
  logic signed [ACC_W-1:0] numer_next;
  logic signed [ACC_W-1:0] denom_next;
  logic signed [TERM_W-1:0] numer_term;
  logic signed [TERM_W-1:0] denom_term;
  logic signed [ACC_W:0]   numer_sum;
  logic signed [ACC_W:0]   denom_sum;
  logic                    advance;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
    logic signed [ACC_W-1:0] r;
    if (s > $signed({ACC_MAX[ACC_W-1], ACC_MAX})) begin
      r = ACC_MAX;
    end else if (s < $signed({ACC_MIN[ACC_W-1], ACC_MIN})) begin
      r = ACC_MIN;
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // the element pipe only holds when a finished vector cannot enter the queue
  assign advance  = !(s1_valid && s1_last && q_full);
  assign in_stall = !advance;

  assign numer_term = TERM_W'(p_rr) + TERM_W'(p_ii);
  assign denom_term = TERM_W'(p_vr) + TERM_W'(p_vi);
  assign numer_sum  = (ACC_W+1)'(numer_acc) + (ACC_W+1)'(numer_term);
  assign denom_sum  = (ACC_W+1)'(denom_acc) + (ACC_W+1)'(denom_term);
  assign numer_next = sat_acc(numer_sum);
  assign denom_next = sat_acc(denom_sum);

  assign push            = s1_valid && s1_last && !q_full;
  assign push_data.numer = numer_next;
  assign push_data.denom = denom_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      numer_acc <= '0;
      denom_acc <= '0;
    end else if (advance) begin
      s1_valid <= in_valid;
      if (s1_valid) begin
        if (s1_last) begin
          numer_acc <= '0;
          denom_acc <= '0;
        end else begin
          numer_acc <= numer_next;
          denom_acc <= denom_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last <= last_elem;
      p_rr    <= vec_re * prod_re;
      p_ii    <= vec_im * prod_im;
      p_vr    <= vec_re * vec_re;
      p_vi    <= vec_im * vec_im;
    end
  end

endmodule
`default_nettype wire

@@ src/rq_queue.sv @@
// short queue of finished sums between front and back end
`default_nettype none
module rq_queue import rq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire rq_sums_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          q_valid,
  output rq_sums_t      q_data
);

  rq_sums_t         entries [Q_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full    = count == CNT_W'(Q_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = entries[rptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ src/rq_back.sv @@
// back end: rounded restoring division, saturation and result register
`default_nettype none
module rq_back import rq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire rq_sums_t    q_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] quotient,
  output logic             zero_norm,
  output logic             saturated
);

  rq_state_t         state;
  rq_state_t         state_next;
  logic              neg;
  logic              zero;
  logic [ACC_W-1:0]  mag;
  logic [ACC_W-2:0]  den;
  logic [ACC_W-1:0]  rem;
  logic [OUT_W-1:0]  low;
  logic [OUT_W-1:0]  quo;
  logic              ovf;
  logic [4:0]        cnt;
  logic              load_out;
  logic              prep;
  logic              div_step;
  logic [63:0]       dividend;
  logic [ACC_W-1:0]  trial;
  logic              ge;
  logic [OUT_W-1:0]  res_value;
  logic              res_sat;

  // dividend = |numer| * 2^16 + den/2 gives round half away from zero
  assign dividend = {mag, 16'b0} + {18'b0, den[ACC_W-2:1]};
  assign trial    = {rem[ACC_W-2:0], low[OUT_W-1]};
  assign ge       = trial >= {1'b0, den};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (cnt == '0) state_next = ST_FINISH;
      ST_FINISH: if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    prep     = 1'b0;
    div_step = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   pop = q_valid;
      ST_PREP:   prep = 1'b1;
      ST_DIVIDE: div_step = 1'b1;
      ST_FINISH: load_out = !out_valid || !out_stall;
      default:   pop = 1'b0;
    endcase
  end

  always_comb begin
    res_value = quo;
    res_sat   = 1'b0;
    priority if (zero) begin
      res_value = '0;
    end else if (!neg) begin
      if (ovf || quo[OUT_W-1]) begin
        res_value = OUT_POS_MAX;
        res_sat   = 1'b1;
      end
    end else begin
      if (ovf || quo > OUT_NEG_MAX) begin
        res_value = OUT_NEG_MAX;
        res_sat   = 1'b1;
      end else begin
        res_value = -quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      neg  <= q_data.numer[ACC_W-1];
      zero <= q_data.denom[ACC_W-1] || (q_data.denom == '0);
      mag  <= q_data.numer[ACC_W-1] ? ACC_W'(-q_data.numer) : ACC_W'(q_data.numer);
      den  <= q_data.denom[ACC_W-2:0];
    end
    if (prep) begin
      // a high half not below the divisor means the quotient needs more than 32 bits
      ovf <= {16'b0, dividend[63:32]} >= {1'b0, den};
      rem <= {16'b0, dividend[63:32]};
      low <= dividend[31:0];
      cnt <= 5'd31;
    end
    if (div_step) begin
      rem <= ge ? trial - {1'b0, den} : trial;
      low <= {low[OUT_W-2:0], 1'b0};
      quo <= {quo[OUT_W-2:0], ge};
      cnt <= cnt - 5'd1;
    end
    if (load_out) begin
      quotient   <= $signed(res_value);
      zero_norm  <= zero;
      saturated  <= res_sat;
    end
  end

endmodule
`default_nettype wire

@@ src/rayleigh_quotient_core.sv @@
// top level of the rayleigh quotient core
//
//  channel   direction  handshake            beat contents
//  in        sink       in_valid/in_stall    vec_re vec_im prod_re prod_im last_elem
//  out       source     out_valid/out_stall  quotient zero_norm saturated
//
// the front end takes one element beat per cycle into the multiply-accumulators while in_stall is low
// the back end works on one vector at a time: pop, setup, 32 divide steps, output load
// a two-entry queue of finished sums lets short vectors run ahead of the divider
// in_stall rises only when a last element finds the queue full
// rst clears accumulators, queue pointers, divider state and out_valid
`default_nettype none
module rayleigh_quotient_core import rq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] vec_re,
  input  wire logic signed [15:0] vec_im,
  input  wire logic signed [15:0] prod_re,
  input  wire logic signed [15:0] prod_im,
  input  wire logic               last_elem,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      quotient,
  output logic                    zero_norm,
  output logic                    saturated
);

  logic     push;
  rq_sums_t push_data;
  logic     q_full;
  logic     q_valid;
  rq_sums_t q_data;
  logic     pop;

  rq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .vec_re    (vec_re),
    .vec_im    (vec_im),
    .prod_re   (prod_re),
    .prod_im   (prod_im),
    .last_elem (last_elem),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  rq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .quotient   (quotient),
    .zero_norm  (zero_norm),
    .saturated  (saturated)
  );

endmodule
`default_nettype wire

@@ src/rq_checker.sv @@
// port-level checks for the rayleigh quotient core and their bind
`default_nettype none
module rq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] quotient,
  input wire logic               zero_norm,
  input wire logic               saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(quotient) && $stable(zero_norm) && $stable(saturated))
    else $error("stalled result beat changed");

  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_norm |-> quotient == 32'sd0 && !saturated)
    else $error("zero norm result not forced to zero");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      quotient == 32'sh7fffffff || quotient == 32'sh80000000)
    else $error("saturated result not at a range limit");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("core not idle after reset");

endmodule

bind rayleigh_quotient_core rq_checker u_rq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .quotient   (quotient),
  .zero_norm  (zero_norm),
  .saturated  (saturated)
);
`default_nettype wire
